// ----- rtl/swer_pkg.sv -----
package swer_pkg;

  // Default ring depth in samples
  localparam int unsigned WINDOW_DEFAULT = 60;

  localparam int unsigned COUNT_W      = 16;
  localparam int unsigned TOTAL_OUT_W  = 22;
  localparam int unsigned PERIOD_W     = 16;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;

  localparam logic [COUNT_W-1:0]     COUNT_MAX      = 16'hFFFF;
  localparam logic [TOTAL_OUT_W-1:0] TOTAL_MAX      = 22'h3FFFFF;
  localparam logic [PERIOD_W-1:0]    PERIOD_DEFAULT = 16'd1000;

  // Register index of sample_period_ms
  localparam logic REG_PERIOD = 1'b0;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [TOTAL_OUT_W-1:0] window_total;
    logic                   sample_closed;
  } out_word_t;

  // Ring operation handed from the control stage to the ring stage
  typedef struct packed {
    logic               close;
    logic               clear;
    logic [COUNT_W-1:0] count;
  } swer_op_t;

endpackage

// ----- rtl/sliding_window_event_rate.sv -----
// Sliding-window event-rate meter. Key events bump a saturating count; a time
// tick closes a sample once the wrapped time since the last sample reaches
// sample_period_ms (register at byte address 0), pushes the count into a ring
// of WINDOW samples and reports the ring sum. Every input word yields exactly
// one result word. The block takes one word per cycle while its input is not
// stalled; an accepted word passes through the ring stage and then the output
// register. While the output is stalled the block holds one word in the ring
// stage and one in the output register, then stalls its input. The ring memory
// is read when a word is accepted and written when it retires, with a
// forwarding path for closes that hit the same slot in consecutive words.
// Reset and the clear word empty the ring at once; there is no clearing pass.
module sliding_window_event_rate import swer_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEFAULT,
  localparam int unsigned POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_word_t           in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_word_t          out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [PERIOD_W-1:0] period_q;
  logic                accept;
  logic                advance;
  logic                s2_valid;
  swer_op_t            op;
  logic [POS_W-1:0]    pos;
  out_word_t           result;
  logic                out_valid_q;
  out_word_t           out_word_q;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_DEFAULT;
    end else if (psel && penable && pwrite && (paddr[2] == REG_PERIOD)) begin
      period_q <= pwdata[PERIOD_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_PERIOD) ? PDATA_W'(period_q) : '0;

  // Handshake: the ring stage moves on whenever the output register is free
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s2_valid && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  swer_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_word_i(in_word_i),
    .period_i (period_q),
    .op_o     (op),
    .pos_o    (pos)
  );

  swer_ring #(.WINDOW(WINDOW)) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (op),
    .pos_i    (pos),
    .advance_i(advance),
    .valid_o  (s2_valid),
    .result_o (result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_valid) out_word_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- rtl/swer_ctrl.sv -----
module swer_ctrl import swer_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEFAULT,
  localparam int unsigned POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  in_word_t            in_word_i,
  input  logic [PERIOD_W-1:0] period_i,
  output swer_op_t            op_o,
  output logic [POS_W-1:0]    pos_o
);

  logic [COUNT_W-1:0] count_q, count_d;
  logic [31:0]        last_q, last_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [31:0]        elapsed;
  logic               is_close;

  // Wrapped time since the anchoring tick or the last closed sample
  assign elapsed  = in_word_i.now_ms - last_q;
  assign is_close = (in_word_i.kind == KIND_TICK) && (last_q != 32'd0) &&
                    (elapsed >= {16'd0, period_i});

  // Decide the operation for this word and advance the control state
  always_comb begin
    count_d = count_q;
    last_d  = last_q;
    pos_d   = pos_q;
    op_o    = '{close: 1'b0, clear: 1'b0, count: count_q};
    case (in_word_i.kind)
      KIND_EVENT: begin
        if (count_q != COUNT_MAX) count_d = count_q + COUNT_W'(1);
      end
      KIND_TICK: begin
        if (last_q == 32'd0) begin
          last_d = in_word_i.now_ms;
        end else if (is_close) begin
          op_o.close = 1'b1;
          count_d    = '0;
          last_d     = in_word_i.now_ms;
          pos_d      = (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + POS_W'(1);
        end
      end
      KIND_CLEAR: begin
        op_o.clear = 1'b1;
        count_d    = '0;
        last_d     = '0;
        pos_d      = '0;
      end
      default: ;
    endcase
  end

  assign pos_o = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      last_q  <= '0;
      pos_q   <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
      last_q  <= last_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ----- rtl/swer_ring.sv -----
module swer_ring import swer_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEFAULT,
  localparam int unsigned POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int unsigned TOTAL_W = COUNT_W + $clog2(WINDOW),
  localparam int unsigned CMP_W   = (TOTAL_W > TOTAL_OUT_W) ? TOTAL_W : TOTAL_OUT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  swer_op_t         op_i,
  input  logic [POS_W-1:0] pos_i,
  input  logic             advance_i,
  output logic             valid_o,
  output out_word_t        result_o
);

  logic [COUNT_W-1:0] ring_mem_q [WINDOW];
  logic [COUNT_W-1:0] rdata_q;
  logic [WINDOW-1:0]  entry_valid_q;
  logic               s2_valid_q;
  swer_op_t           op_q;
  logic [POS_W-1:0]   pos_q;
  logic               fwd_q;
  logic [COUNT_W-1:0] fwd_data_q;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [COUNT_W-1:0] old_sample;
  logic [CMP_W-1:0]   total_ext;
  logic               retire;
  logic               wr_en;

  assign retire = s2_valid_q && advance_i;
  assign wr_en  = retire && op_q.close;

  // Hold the word in the ring stage until the output register takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (accept_i) begin
      s2_valid_q <= 1'b1;
    end else if (advance_i) begin
      s2_valid_q <= 1'b0;
    end
  end

  // Capture the operation and the forwarding decision for a back-to-back hit
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q       <= op_i;
      pos_q      <= pos_i;
      fwd_q      <= wr_en && (pos_q == pos_i);
      fwd_data_q <= op_q.count;
    end
  end

  // Ring memory: read the slot to be overwritten, write back the closed sample
  always_ff @(posedge clk_i) begin
    if (accept_i && op_i.close) rdata_q <= ring_mem_q[pos_i];
    if (wr_en) ring_mem_q[pos_q] <= op_q.count;
  end

  // Slots never written since reset or clear read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
    end else if (retire) begin
      if (op_q.clear) entry_valid_q <= '0;
      else if (op_q.close) entry_valid_q[pos_q] <= 1'b1;
    end
  end

  always_comb begin
    if (!entry_valid_q[pos_q]) old_sample = '0;
    else if (fwd_q) old_sample = fwd_data_q;
    else old_sample = rdata_q;
  end

  // Running sum: add the new sample, drop the one it replaces; a clear empties it
  always_comb begin
    total_d = total_q;
    if (op_q.clear) total_d = '0;
    else if (op_q.close) total_d = total_q + TOTAL_W'(op_q.count) - TOTAL_W'(old_sample);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (retire) begin
      total_q <= total_d;
    end
  end

  // Saturate the reported total
  assign total_ext = CMP_W'(total_d);
  always_comb begin
    if (total_ext > CMP_W'(TOTAL_MAX)) result_o.window_total = TOTAL_MAX;
    else result_o.window_total = total_ext[TOTAL_OUT_W-1:0];
    result_o.sample_closed = op_q.close;
  end

  assign valid_o = s2_valid_q;

endmodule

// ----- rtl/swer_checker.sv -----
module swer_assertions import swer_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input in_word_t           in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input out_word_t          out_word_o,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // Stall input only when the output register is full and held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A fresh result follows an accepted word through the ring stage and the output register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without matching input word");

  // Read back the period just written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == REG_PERIOD) |=>
    !(psel && !pwrite && (paddr[2] == REG_PERIOD)) ||
    (prdata[PERIOD_W-1:0] == $past(pwdata[PERIOD_W-1:0])))
    else $error("period readback mismatch");

endmodule

bind sliding_window_event_rate swer_assertions u_swer_assertions (.*);

// ----- bench/swer_checker.sv -----
module swer_checker import swer_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_word_t           in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_word_t          out_word_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  output int                 pending_o,
  output int                 fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PRINT_LIMIT = 40;
  localparam logic [PADDR_W-1:0] PERIOD_ADDR = PADDR_W'({REG_PERIOD, 2'b00});

  // Shadow of the meter: register, count, sample ring and running sum
  logic [PERIOD_W-1:0] period_q;
  logic [COUNT_W-1:0]  count_q;
  logic [COUNT_W-1:0]  ring_q [WINDOW];
  int unsigned         slot_q;
  logic [31:0]         sum_q;
  logic [31:0]         anchor_q;

  // Results still owed by the block, oldest first
  out_word_t           owed_totals_q [$];
  int                  mismatches;

  function automatic void clear_meter();
    count_q  = '0;
    foreach (ring_q[i]) ring_q[i] = '0;
    slot_q   = 0;
    sum_q    = '0;
    anchor_q = '0;
  endfunction

  // Advance the shadow by one input word and return the word it should report
  function automatic out_word_t meter_step(in_word_t w);
    out_word_t   r;
    logic        closed;
    logic [31:0] elapsed;
    closed = 1'b0;
    case (w.kind)
      KIND_EVENT: begin
        if (count_q != COUNT_MAX) count_q = count_q + 1'b1;
      end
      KIND_TICK: begin
        elapsed = w.now_ms - anchor_q;
        if (anchor_q == '0) begin
          anchor_q = w.now_ms;
        end else if (elapsed >= 32'(period_q)) begin
          // Close the sample: swap the oldest ring entry for the count
          sum_q          = sum_q - 32'(ring_q[slot_q]) + 32'(count_q);
          ring_q[slot_q] = count_q;
          slot_q         = (slot_q + 1) % WINDOW;
          count_q        = '0;
          anchor_q       = w.now_ms;
          closed         = 1'b1;
        end
      end
      KIND_CLEAR: clear_meter();
      default: ;
    endcase
    r.window_total  = (sum_q > 32'(TOTAL_MAX)) ? TOTAL_MAX : sum_q[TOTAL_OUT_W-1:0];
    r.sample_closed = closed;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t owed;
    if (!rst_ni) begin
      period_q = PERIOD_DEFAULT;
      clear_meter();
      owed_totals_q.delete();
      mismatches = 0;
    end else begin
      // Track register writes, check register reads
      if (psel && penable && pready && paddr == PERIOD_ADDR) begin
        if (pwrite) begin
          period_q = pwdata[PERIOD_W-1:0];
        end else if (prdata[PERIOD_W-1:0] != period_q) begin
          mismatches++;
          if (mismatches <= PRINT_LIMIT)
            $display("%0t: period readback expected %0d, got %0d",
                     $time, period_q, prdata[PERIOD_W-1:0]);
        end
      end
      // Predict each accepted input word
      if (in_valid_i && !in_stall_i) owed_totals_q.push_back(meter_step(in_word_i));
      // Compare each accepted result word with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (owed_totals_q.size() == 0) begin
          mismatches++;
          if (mismatches <= PRINT_LIMIT)
            $display("%0t: unexpected result, got total %0d closed %0b",
                     $time, out_word_i.window_total, out_word_i.sample_closed);
        end else begin
          owed = owed_totals_q.pop_front();
          if (out_word_i.window_total != owed.window_total) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
              $display("%0t: window_total expected %0d, got %0d",
                       $time, owed.window_total, out_word_i.window_total);
          end
          if (out_word_i.sample_closed != owed.sample_closed) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
              $display("%0t: sample_closed expected %0b, got %0b",
                       $time, owed.sample_closed, out_word_i.sample_closed);
          end
        end
      end
    end
    pending_o    = owed_totals_q.size();
    fail_count_o = mismatches + owed_totals_q.size();
  end

endmodule

// ----- bench/sliding_window_event_rate_tb.sv -----
module sliding_window_event_rate_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swer_pkg::*;

  localparam int unsigned WINDOW         = WINDOW_DEFAULT;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned BURST_WORDS    = 24;
  localparam logic [1:0]  KIND_UNUSED    = 2'd3;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  in_word_t           in_word_i   = '0;
  logic               out_stall_i = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  out_word_t          out_word_o;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int                 pending;
  int                 fail_count;
  logic               long_hold_req = 1'b0;
  int unsigned        burst_left = 0;

  sliding_window_event_rate #(.WINDOW(WINDOW)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  swer_checker #(.WINDOW(WINDOW)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(25, 80);
  endfunction

  // Offer one word after an optional gap, hold it until accepted
  task automatic send_word(input logic [1:0] kind, input logic [31:0] now,
                           input int unsigned gap);
    in_word_t w;
    w.kind   = kind;
    w.now_ms = now;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Send with random idling, with occasional bursts of back-to-back words
  task automatic send(input logic [1:0] kind, input logic [31:0] now);
    int unsigned gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 49) == 0) begin
      burst_left = $urandom_range(20, 40);
    end else begin
      gap = pick_gap();
    end
    send_word(kind, now, gap);
  endtask

  task automatic apb_access(input logic write, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= PADDR_W'({REG_PERIOD, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid and wait until every owed result has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the period while idle and read it back
  task automatic set_period(input logic [PERIOD_W-1:0] value);
    drain();
    apb_access(1'b1, {16'($urandom), value});
    apb_access(1'b0, PDATA_W'($urandom));
  endtask

  // Random words: mostly events and ticks on an advancing clock, some noise
  task automatic run_phase(input int unsigned n_words, input logic [31:0] start_ms,
                           input int unsigned span, input bit allow_clear);
    logic [31:0] clock_ms;
    int unsigned r;
    clock_ms = start_ms;
    repeat (n_words) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send(KIND_EVENT, $urandom);
      end else if (r < 85) begin
        clock_ms = clock_ms + $urandom_range(0, span);
        send(KIND_TICK, clock_ms);
      end else if (r < 90) begin
        send(KIND_TICK, $urandom);
      end else if (r < 93) begin
        send(KIND_TICK, 32'd0);
      end else if (r < 96 && allow_clear) begin
        send(KIND_CLEAR, $urandom);
      end else if (r < 98) begin
        send(KIND_UNUSED, $urandom);
      end else begin
        send(KIND_EVENT, $urandom);
      end
    end
  endtask

  // Receiver: one long hold-off once asked, otherwise random stalls
  initial begin
    int unsigned n;
    bit          hold_done;
    hold_done = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int unsigned idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pready))
        idle = 0;
      else
        idle++;
    end
    $display("sliding_window_event_rate_tb: FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Check the reset value of the period
    apb_access(1'b0, '0);

    // Directed: anchoring, wrapped differences, closing at zero, clear, unused kind
    send(KIND_EVENT, 32'hFFFF_FFFF);
    send(KIND_TICK, 32'd0);
    send(KIND_TICK, 32'hFFFF_FC18);
    send(KIND_EVENT, 32'd0);
    send(KIND_EVENT, $urandom);
    send(KIND_EVENT, $urandom);
    send(KIND_TICK, 32'hFFFF_FFFF);
    send(KIND_TICK, 32'd0);
    send(KIND_TICK, 32'd1234);
    send(KIND_EVENT, $urandom);
    send(KIND_UNUSED, 32'hFFFF_FFFF);
    send(KIND_TICK, 32'd2233);
    send(KIND_TICK, 32'd2234);
    send(KIND_CLEAR, 32'hA5A5_5A5A);
    send(KIND_EVENT, 32'h5A5A_A5A5);
    send(KIND_TICK, 32'hFFFF_FFFF);
    send(KIND_TICK, 32'd999);
    send(KIND_TICK, 32'd999);

    // Period of zero: every anchored tick closes
    set_period('0);
    send(KIND_TICK, 32'd77);
    send(KIND_TICK, 32'd77);

    // Largest period
    set_period(16'hFFFF);
    send(KIND_TICK, 32'd77 + 32'd65534);
    send(KIND_TICK, 32'd77 + 32'd65535);

    // Back-to-back events within one sample
    set_period(PERIOD_DEFAULT);
    send(KIND_TICK, 32'd200000);
    repeat (BURST_WORDS) send_word(KIND_EVENT, $urandom, 0);
    send(KIND_TICK, 32'd201000);
    send(KIND_EVENT, $urandom);
    send(KIND_TICK, 32'd202000);

    // Random phases over several periods; the receiver holds off at the start
    set_period('0);
    long_hold_req <= 1'b1;
    run_phase(120, $urandom, 3, 1'b1);

    set_period(16'd1);
    run_phase(300, $urandom, 6, 1'b0);

    set_period(16'hFFFF);
    run_phase(120, 32'hFFF0_0000, 131074, 1'b1);

    set_period(16'($urandom_range(2, 3000)));
    run_phase(110, $urandom, 6000, 1'b1);

    set_period(PERIOD_DEFAULT);
    run_phase(100, $urandom, 2004, 1'b1);

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0)
      $display("sliding_window_event_rate_tb: PASS");
    else
      $display("sliding_window_event_rate_tb: FAIL");
    $finish;
  end

endmodule
